[rtl/mft_pkg.sv]
// shared types and constants for the manchester frame transmitter
// no dependencies

package mft_pkg;

  localparam int unsigned PosWidth = 6;
  localparam int unsigned ByteWidth = 8;

  localparam logic [ByteWidth-1:0] CmdStar = 8'h2A;
  localparam logic [ByteWidth-1:0] CmdHash = 8'h23;

  localparam logic [PosWidth-1:0] ToggleEnd   = 6'd10;
  localparam logic [PosWidth-1:0] PreambleEnd = 6'd16;
  localparam logic [PosWidth-1:0] SyncEnd     = 6'd17;
  localparam logic [PosWidth-1:0] LastPos     = 6'd33;

  typedef enum logic {
    ReqTick = 1'b0,
    ReqByte = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [PosWidth-1:0]  frame_pos;
    logic                 byte_select;
    logic [ByteWidth-1:0] cmd_byte;
    logic [ByteWidth-1:0] pay_byte;
    logic                 sending;
    logic                 line;
  } tx_state_t;

  typedef struct packed {
    logic line_level;
    logic frame_done;
  } tx_result_t;

endpackage

[rtl/mft_in_if.sv]
// input channel of the frame transmitter: request type and received byte
// depends on mft_pkg

interface mft_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [mft_pkg::ByteWidth-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

[rtl/mft_out_if.sv]
// result channel of the frame transmitter: line level and frame end flag
// no dependencies

interface mft_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic frame_done;

  modport source (output valid, output line_level, output frame_done, input ready);
  modport sink   (input valid, input line_level, input frame_done, output ready);
endinterface

[rtl/manchester_frame_transmitter_core.sv]
// top level of the manchester frame transmitter with preamble
// depends on mft_pkg, mft_in_if, mft_out_if, mft_frame_logic, mft_out_stage
//
// in_i carries one transfer per item: req_type 0 is a bit-clock tick,
// req_type 1 a received byte in rx_byte. '*' or '#' becomes the command
// byte and stops sending; any other byte becomes the payload and starts it.
// out_o gives exactly one result per item: the line level after the item
// and frame_done, high on the tick that ends a 34-tick frame.
// the result is registered and is valid in the cycle after the input
// transfer. throughput is one item per cycle, set by the single result
// register, which accepts a new item whenever it is empty or being read.
// when the receiver stalls, the result register holds and in_i.ready falls
// until it is taken; frame state only moves on an accepted input transfer.
// reset clears the frame position, both bytes, the byte select (command
// byte first), the sending flag and the line (low), and empties the
// result register.

module manchester_frame_transmitter_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  mft_in_if.sink   in_i,
  mft_out_if.source out_o
);

  mft_pkg::tx_state_t  state_q;
  mft_pkg::tx_state_t  state_d;
  mft_pkg::tx_result_t result;
  logic                free;
  logic                accept;

  assign in_i.ready = free;
  assign accept     = in_i.valid & free;

  mft_frame_logic u_logic (
    .state_i    (state_q),
    .req_type_i (in_i.req_type),
    .rx_byte_i  (in_i.rx_byte),
    .state_o    (state_d),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  mft_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .free_o   (free),
    .out_o    (out_o)
  );

endmodule

[rtl/mft_frame_logic.sv]
// next-state and result logic for one transfer of the frame transmitter
// depends on mft_pkg

module mft_frame_logic (
  input  mft_pkg::tx_state_t           state_i,
  input  logic                         req_type_i,
  input  logic [mft_pkg::ByteWidth-1:0] rx_byte_i,
  output mft_pkg::tx_state_t           state_o,
  output mft_pkg::tx_result_t          result_o
);

  logic [mft_pkg::ByteWidth-1:0] data_byte;
  logic [mft_pkg::PosWidth-1:0]  data_off;
  logic [2:0]                    bit_idx;
  logic                          data_bit;
  logic                          level;
  logic                          last_tick;

  assign data_byte = state_i.byte_select ? state_i.pay_byte : state_i.cmd_byte;
  assign data_off  = state_i.frame_pos - mft_pkg::SyncEnd;
  assign bit_idx   = data_off[3:1];
  assign data_bit  = data_byte[bit_idx];
  assign last_tick = (state_i.frame_pos >= mft_pkg::LastPos);

  always_comb begin
    priority if (state_i.frame_pos == '0) begin
      level = 1'b1;
    end else if (state_i.frame_pos < mft_pkg::ToggleEnd) begin
      level = ~state_i.line;
    end else if (state_i.frame_pos < mft_pkg::PreambleEnd) begin
      level = 1'b1;
    end else if (state_i.frame_pos < mft_pkg::SyncEnd) begin
      level = 1'b0;
    end else if (last_tick) begin
      level = 1'b0;
    end else begin
      level = state_i.frame_pos[0] ? data_bit : ~data_bit;
    end
  end

  always_comb begin
    state_o             = state_i;
    result_o.frame_done = 1'b0;
    if (req_type_i == mft_pkg::ReqByte) begin
      if (rx_byte_i == mft_pkg::CmdStar || rx_byte_i == mft_pkg::CmdHash) begin
        state_o.cmd_byte = rx_byte_i;
        state_o.sending  = 1'b0;
      end else begin
        state_o.pay_byte = rx_byte_i;
        state_o.sending  = 1'b1;
      end
    end else if (!state_i.sending) begin
      state_o.frame_pos = '0;
    end else if (last_tick) begin
      state_o.line        = 1'b0;
      state_o.frame_pos   = '0;
      state_o.byte_select = ~state_i.byte_select;
      result_o.frame_done = 1'b1;
    end else begin
      state_o.line      = level;
      state_o.frame_pos = state_i.frame_pos + 1'b1;
    end
    result_o.line_level = state_o.line;
  end

endmodule

[rtl/mft_out_stage.sv]
// result register between the frame logic and the result channel
// depends on mft_pkg and mft_out_if

module mft_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  mft_pkg::tx_result_t result_i,
  output logic                free_o,
  mft_out_if.source           out_o
);

  logic                valid_q;
  logic                valid_d;
  mft_pkg::tx_result_t result_q;

  assign free_o  = ~valid_q | out_o.ready;
  assign valid_d = load_i | (valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.line_level = result_q.line_level;
  assign out_o.frame_done = result_q.frame_done;

endmodule

[sim/manchester_frame_transmitter_core_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for manchester_frame_transmitter_core: random
// bytes and ticks with random idling, checked against an in-bench frame predictor
// depends on mft_pkg, mft_in_if, mft_out_if and the core

module manchester_frame_transmitter_core_test;

  localparam int ItemTarget = 850;
  localparam int GapMax     = 5;
  localparam int HoldAfter  = 300;
  localparam int HoldCycles = 80;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 4;
  localparam int ByteBits   = mft_pkg::ByteWidth;

  typedef struct packed {
    mft_pkg::req_type_e            kind;
    logic [mft_pkg::ByteWidth-1:0] rx;
  } tx_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mft_in_if  tx_in ();
  mft_out_if tx_out ();

  manchester_frame_transmitter_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tx_in),
    .out_o (tx_out)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tx_item_t            pending_items[$];
  mft_pkg::tx_result_t line_expect[$];

  // predicted frame state
  logic [mft_pkg::PosWidth-1:0]  tx_pos;
  logic                          tx_sel;
  logic [mft_pkg::ByteWidth-1:0] cmd_byte;
  logic [mft_pkg::ByteWidth-1:0] pay_byte;
  logic                          tx_on;
  logic                          tx_line;

  int   n_accepted  = 0;
  int   n_bytes     = 0;
  int   n_frames    = 0;
  int   n_results   = 0;
  int   n_errors    = 0;
  int   send_wait   = 0;
  int   recv_wait   = 0;
  int   stall_count = 0;
  logic hold_off    = 1'b0;

  function automatic logic burst_phase();
    return (n_accepted / 100) % 3 == 2;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", n_results, what);
    n_errors++;
  endtask

  task automatic advance_frame(input mft_pkg::req_type_e kind,
                               input logic [mft_pkg::ByteWidth-1:0] rx);
    mft_pkg::tx_result_t           res;
    logic [mft_pkg::ByteWidth-1:0] data;
    logic [mft_pkg::PosWidth-1:0]  off;
    logic                          bit_val;
    res.frame_done = 1'b0;
    if (kind == mft_pkg::ReqByte) begin
      if (rx == mft_pkg::CmdStar || rx == mft_pkg::CmdHash) begin
        cmd_byte = rx;
        tx_on    = 1'b0;
      end else begin
        pay_byte = rx;
        tx_on    = 1'b1;
      end
    end else if (!tx_on) begin
      tx_pos = '0;
    end else begin
      data = tx_sel ? pay_byte : cmd_byte;
      off  = tx_pos - mft_pkg::SyncEnd;
      if (tx_pos == '0) begin
        tx_line = 1'b1;
      end else if (tx_pos < mft_pkg::ToggleEnd) begin
        tx_line = ~tx_line;
      end else if (tx_pos < mft_pkg::PreambleEnd) begin
        tx_line = 1'b1;
      end else if (tx_pos < mft_pkg::SyncEnd || tx_pos >= mft_pkg::LastPos) begin
        tx_line = 1'b0;
      end else begin
        bit_val = data[off[3:1]];
        tx_line = tx_pos[0] ? bit_val : ~bit_val;
      end
      tx_pos = tx_pos + 1'b1;
      if (tx_pos > mft_pkg::LastPos) begin
        tx_line        = 1'b0;
        tx_pos         = '0;
        tx_sel         = ~tx_sel;
        res.frame_done = 1'b1;
      end
    end
    res.line_level = tx_line;
    line_expect.push_back(res);
  endtask

  task automatic push_ticks(input int count);
    tx_item_t item;
    item.kind = mft_pkg::ReqTick;
    for (int i = 0; i < count; i++) begin
      item.rx = ByteBits'($urandom_range(0, 255));
      pending_items.push_back(item);
    end
  endtask

  task automatic push_byte(input logic [mft_pkg::ByteWidth-1:0] rx);
    tx_item_t item;
    item.kind = mft_pkg::ReqByte;
    item.rx   = rx;
    pending_items.push_back(item);
  endtask

  function automatic logic [mft_pkg::ByteWidth-1:0] pick_payload();
    logic [mft_pkg::ByteWidth-1:0] b;
    do
      b = ByteBits'($urandom_range(0, 255));
    while (b == mft_pkg::CmdStar || b == mft_pkg::CmdHash);
    return b;
  endfunction

  function automatic logic [mft_pkg::ByteWidth-1:0] pick_command();
    return $urandom_range(0, 1) ? mft_pkg::CmdStar : mft_pkg::CmdHash;
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_items
    tx_item_t item;
    logic     launch;
    if (!rst_ni) begin
      tx_in.valid <= 1'b0;
      send_wait = 0;
      tx_pos    = '0;
      tx_sel    = 1'b0;
      cmd_byte  = '0;
      pay_byte  = '0;
      tx_on     = 1'b0;
      tx_line   = 1'b0;
    end else begin
      if (tx_in.valid && tx_in.ready) begin
        advance_frame(mft_pkg::req_type_e'(tx_in.req_type), tx_in.rx_byte);
        if (tx_in.req_type == mft_pkg::ReqByte) n_bytes++;
        n_accepted++;
        send_wait = burst_phase() ? 0 : $urandom_range(0, GapMax);
      end
      if (!tx_in.valid || tx_in.ready) begin
        launch = 1'b0;
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_items.size() != 0) begin
          item = pending_items.pop_front();
          tx_in.req_type <= item.kind;
          tx_in.rx_byte  <= item.rx;
          launch = 1'b1;
        end
        tx_in.valid <= launch;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_line
    mft_pkg::tx_result_t want;
    if (!rst_ni) begin
      tx_out.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (tx_out.valid && tx_out.ready) begin
        if (line_expect.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = line_expect.pop_front();
          if (tx_out.line_level !== want.line_level)
            report_mismatch($sformatf("line_level got %b want %b",
                                      tx_out.line_level, want.line_level));
          if (tx_out.frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done got %b want %b",
                                      tx_out.frame_done, want.frame_done));
        end
        if (tx_out.frame_done === 1'b1) n_frames++;
        n_results++;
        recv_wait = burst_phase() ? 0 : $urandom_range(0, GapMax);
      end
      if (hold_off) begin
        tx_out.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        tx_out.ready <= 1'b0;
      end else begin
        tx_out.ready <= 1'b1;
      end
    end
  end

  // long receiver stall so the result register fills and input backs up
  initial begin
    while (n_accepted < HoldAfter) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tx_in.valid && tx_in.ready) || (tx_out.valid && tx_out.ready))
      stall_count = 0;
    else
      stall_count++;
    if (stall_count >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int total;
    int scenario;
    int k;
    tx_item_t item;
    tx_in.valid    = 1'b0;
    tx_in.req_type = mft_pkg::ReqTick;
    tx_in.rx_byte  = '0;
    tx_out.ready   = 1'b0;

    // directed: idle tick, both commands, extremes, stop and resume mid-frame
    push_ticks(1);
    push_byte(mft_pkg::CmdHash);
    push_byte(8'hFF);
    push_ticks(10);
    push_byte(mft_pkg::CmdStar);
    push_ticks(1);
    push_byte(8'h00);
    push_ticks(5);
    push_byte(mft_pkg::CmdHash);
    push_byte(8'h55);
    push_ticks(3);

    while (pending_items.size() < ItemTarget) begin
      scenario = $urandom_range(0, 9);
      if (scenario <= 5) begin
        if ($urandom_range(0, 1)) push_byte(pick_command());
        push_byte(pick_payload());
        push_ticks($urandom_range(34, 72));
      end else if (scenario == 6) begin
        // payload changes while a frame is in flight
        push_byte(pick_payload());
        push_ticks($urandom_range(10, 30));
        push_byte(pick_payload());
        push_ticks($urandom_range(10, 40));
      end else if (scenario == 7) begin
        // stop mid-frame, maybe clear by an idle tick, then resume
        push_byte(pick_payload());
        push_ticks($urandom_range(1, 33));
        push_byte(pick_command());
        push_ticks($urandom_range(0, 2));
        push_byte(pick_payload());
        push_ticks($urandom_range(5, 40));
      end else begin
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
          item.kind = mft_pkg::req_type_e'($urandom_range(0, 1));
          item.rx   = ($urandom_range(0, 3) == 0) ? pick_command()
                                                  : ByteBits'($urandom_range(0, 255));
          pending_items.push_back(item);
        end
      end
    end
    total = pending_items.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < total || line_expect.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (line_expect.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", line_expect.size()));

    $display("covered %0d items (%0d bytes), %0d results, %0d complete frames,",
             n_accepted, n_bytes, n_results, n_frames);
    $display("with random idling on both sides and one %0d-cycle receiver stall",
             HoldCycles);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
